// ----- rtl/arbs_pkg.sv -----
// ============================================================================
// arbs_pkg - shared definitions for the auto-repeat button service unit
// Timer width, register map, opcodes and the configuration bundle.
// ============================================================================
package arbs_pkg;

    // Hold timer width (8 .. 32).
    localparam int TIMER_BITS = 16;

    localparam int DEBOUNCE_W   = 16;
    localparam int CMP_W        = (TIMER_BITS > DEBOUNCE_W) ? TIMER_BITS : DEBOUNCE_W;
    localparam int MIN_DEBOUNCE = 20;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef logic [TIMER_BITS-1:0] timer_t;

    // Register index, byte address = 4 * index.
    typedef enum logic [1:0] {
        REG_PULLED_UP      = 2'd0,
        REG_NORMALLY_OPEN  = 2'd1,
        REG_DEBOUNCE_TICKS = 2'd2,
        REG_AUTO_REPEAT_ON = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_ACK  = 1'b1
    } op_t;

    typedef struct packed {
        logic                  pulled_up;
        logic                  normally_open;
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic                  auto_repeat_on;
    } cfg_t;

endpackage

// ----- rtl/arbs_in_if.sv -----
// ============================================================================
// arbs_in_if - request channel
// One word per tick sample or acknowledge, valid/ready handshake.
// ============================================================================
interface arbs_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic pin_level;

    modport source (output valid, output opcode, output pin_level, input ready);
    modport sink   (input valid, input opcode, input pin_level, output ready);
endinterface

// ----- rtl/arbs_out_if.sv -----
// ============================================================================
// arbs_out_if - response channel
// One word per request, valid/ready handshake.
// ============================================================================
interface arbs_out_if;
    logic valid;
    logic ready;
    logic accepted;
    logic service_pending;
    logic pressed_now;

    modport source (output valid, output accepted, output service_pending,
                    output pressed_now, input ready);
    modport sink   (input valid, input accepted, input service_pending,
                    input pressed_now, output ready);
endinterface

// ----- rtl/arbs_cfg_regs.sv -----
// ============================================================================
// arbs_cfg_regs - APB configuration registers
// Write in the access phase, debounce writes clamp to the minimum.
// ============================================================================
module arbs_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [arbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [arbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output arbs_pkg::cfg_t                cfg
);
    import arbs_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    reg_idx_t              idx;
    logic                  wr_en;
    logic [DEBOUNCE_W-1:0] deb_wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign deb_wr = pwdata[DEBOUNCE_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_PULLED_UP:      cfg_next.pulled_up      = pwdata[0];
                REG_NORMALLY_OPEN:  cfg_next.normally_open  = pwdata[0];
                REG_DEBOUNCE_TICKS:
                begin
                    if (deb_wr < DEBOUNCE_W'(MIN_DEBOUNCE))
                        cfg_next.debounce_ticks = DEBOUNCE_W'(MIN_DEBOUNCE);
                    else
                        cfg_next.debounce_ticks = deb_wr;
                end
                REG_AUTO_REPEAT_ON: cfg_next.auto_repeat_on = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulled_up      <= 1'b1;
            cfg_reg.normally_open  <= 1'b1;
            cfg_reg.debounce_ticks <= DEBOUNCE_W'(MIN_DEBOUNCE);
            cfg_reg.auto_repeat_on <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_PULLED_UP:      prdata = APB_DATA_W'(cfg_reg.pulled_up);
            REG_NORMALLY_OPEN:  prdata = APB_DATA_W'(cfg_reg.normally_open);
            REG_DEBOUNCE_TICKS: prdata = APB_DATA_W'(cfg_reg.debounce_ticks);
            REG_AUTO_REPEAT_ON: prdata = APB_DATA_W'(cfg_reg.auto_repeat_on);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/arbs_core.sv -----
// ============================================================================
// arbs_core - button qualifier and response register
// Decodes the sample, updates hold state, registers one response per word.
// ============================================================================
module arbs_core (
    input  logic           clk,
    input  logic           rst_n,
    input  arbs_pkg::cfg_t cfg,
    arbs_in_if.sink        req,
    arbs_out_if.source     rsp
);
    import arbs_pkg::*;

    logic   was_pressed_reg,  was_pressed_next;
    logic   rearmed_reg,      rearmed_next;
    logic   pending_reg,      pending_next;
    timer_t hold_reg,         hold_next;
    logic   last_pressed_reg, last_pressed_next;
    logic   acc_next;

    logic   rsp_valid_reg;
    logic   rsp_acc_reg;
    logic   rsp_pend_reg;
    logic   rsp_press_reg;

    logic   take;
    logic   pressed;
    timer_t hold_inc;
    logic   hold_done;

    // Response register drains or is empty: take a new word.
    assign req.ready = ~rsp_valid_reg | rsp.ready;
    assign take      = req.valid & req.ready;

    // Pressed level: pin XOR (pulled_up XNOR normally_open).
    assign pressed   = req.pin_level ^ ~(cfg.pulled_up ^ cfg.normally_open);
    assign hold_inc  = (&hold_reg) ? hold_reg : hold_reg + 1'b1;
    assign hold_done = CMP_W'(hold_inc) >= CMP_W'(cfg.debounce_ticks);

    always_comb
    begin
        was_pressed_next  = was_pressed_reg;
        rearmed_next      = rearmed_reg;
        pending_next      = pending_reg;
        hold_next         = hold_reg;
        last_pressed_next = last_pressed_reg;
        acc_next          = 1'b0;
        case (op_t'(req.opcode))
            OP_TICK:
            begin
                last_pressed_next = pressed;
                hold_next         = hold_inc;
                if (!pending_reg)
                begin
                    acc_next = 1'b1;
                    if (pressed)
                    begin
                        if (cfg.auto_repeat_on | rearmed_reg)
                        begin
                            if (was_pressed_reg)
                            begin
                                if (hold_done)
                                begin
                                    pending_next = 1'b1;
                                    rearmed_next = 1'b0;
                                end
                            end
                            else
                            begin
                                hold_next        = '0;
                                was_pressed_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        was_pressed_next = 1'b0;
                        if (!cfg.auto_repeat_on)
                            rearmed_next = 1'b1;
                    end
                end
            end
            OP_ACK:
            begin
                if (pending_reg)
                begin
                    acc_next     = 1'b1;
                    pending_next = 1'b0;
                    if (cfg.auto_repeat_on)
                    begin
                        rearmed_next     = 1'b1;
                        hold_next        = '0;
                        was_pressed_next = 1'b1;
                    end
                end
            end
            default: acc_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg  <= 1'b0;
            rearmed_reg      <= 1'b0;
            pending_reg      <= 1'b0;
            hold_reg         <= '0;
            last_pressed_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                was_pressed_reg  <= was_pressed_next;
                rearmed_reg      <= rearmed_next;
                pending_reg      <= pending_next;
                hold_reg         <= hold_next;
                last_pressed_reg <= last_pressed_next;
            end
            if (take)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload, loaded with each accepted word.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_acc_reg   <= acc_next;
            rsp_pend_reg  <= pending_next;
            rsp_press_reg <= last_pressed_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.accepted        = rsp_acc_reg;
    assign rsp.service_pending = rsp_pend_reg;
    assign rsp.pressed_now     = rsp_press_reg;

endmodule

// ----- rtl/auto_repeat_button_service_unit.sv -----
// ============================================================================
// auto_repeat_button_service_unit - debounced push button with auto-repeat
// Qualifies millisecond pin samples into service requests cleared by ack.
// ============================================================================
// Each request word is either a millisecond tick with a pin sample or a
// service acknowledge, and each yields exactly one response word. A word is
// taken every clock cycle: the qualifier state and the response register
// update at the same edge, and a new word is accepted while the previous
// response drains. Throughput drops only when the
// downstream side holds ready low with a response already waiting.
// Configuration (APB, byte address 4*index): pulled_up, normally_open,
// debounce_ticks (writes below 20 store 20), auto_repeat_on. Write only
// while no word is in flight.
// ============================================================================
module auto_repeat_button_service_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [arbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [arbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    arbs_in_if.sink                         req,
    arbs_out_if.source                      rsp
);
    import arbs_pkg::*;

    // Live configuration bundle to the qualifier.
    cfg_t cfg;

    arbs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Decode, hold timer, pending flag and the response register.
    arbs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench - auto-repeat button service unit
// Feeds tick and acknowledge words through the request channel, predicts each
// response word from a behavioral copy of the qualifier, and checks them in
// order. Phases cover both polarity settings, the debounce clamp and its
// maximum, auto-repeat on and off, idling on either side and a long
// downstream hold-off.
// ============================================================================
module testbench;
    import arbs_pkg::*;

    localparam int HOLD_OFF_CYCLES  = 120;    // long downstream stall
    localparam int STALL_LIMIT      = 2000;   // cycles without any handshake
    localparam int MAX_SHOWN        = 10;
    localparam int RANDOM_PER_PHASE = 70;

    typedef struct packed {
        op_t  op;
        logic pin;
    } req_word_t;

    typedef struct packed {
        logic accepted;
        logic service_pending;
        logic pressed_now;
    } rsp_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    arbs_in_if  req_if ();
    arbs_out_if rsp_if ();

    auto_repeat_button_service_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_if),
        .rsp     (rsp_if)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Stimulus and scoreboard storage
    // ------------------------------------------------------------------------
    req_word_t req_word_q[$];   // words waiting for the driver
    rsp_word_t rsp_due_q[$];    // predicted responses, oldest first

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_asks     = 0;      // bumped to request one long ready-low stretch
    int hold_seen;
    int hold_left;
    int phase_words;
    int idle_cycles;

    int mismatches = 0;
    int words_out  = 0;
    int n_ticks    = 0;
    int n_refused  = 0;
    int n_acks     = 0;
    int n_cleared  = 0;
    int n_raised   = 0;

    // ------------------------------------------------------------------------
    // Behavioral copy of the qualifier: configuration mirror plus state
    // ------------------------------------------------------------------------
    cfg_t   model_cfg;
    logic   st_was_pressed;
    logic   st_rearmed;
    logic   st_pending;
    logic   st_last_pressed;
    timer_t st_hold;            // elapsed ticks since the hold timer started

    // Advance the button state by one request word, return its response.
    function automatic rsp_word_t button_qualify(req_word_t w);
        rsp_word_t r;
        logic      pressed;
        r = '0;
        if (w.op == OP_TICK)
        begin
            n_ticks++;
            // level decode: pull-up and normally-open each flip the sense
            pressed = w.pin ^ model_cfg.pulled_up ^ model_cfg.normally_open ^ 1'b1;
            st_last_pressed = pressed;
            // timer always runs, saturating, before the compare
            if (st_hold != '1)
                st_hold = st_hold + 1'b1;
            if (st_pending)
            begin
                // refused: the decoded sample is kept and the timer still advances
                n_refused++;
            end
            else
            begin
                if (pressed)
                begin
                    if (model_cfg.auto_repeat_on || st_rearmed)
                    begin
                        if (st_was_pressed)
                        begin
                            if (st_hold >= model_cfg.debounce_ticks)
                            begin
                                st_pending = 1'b1;
                                st_rearmed = 1'b0;
                                n_raised++;
                            end
                        end
                        else
                        begin
                            // press edge starts the hold timer
                            st_hold        = '0;
                            st_was_pressed = 1'b1;
                        end
                    end
                end
                else
                begin
                    st_was_pressed = 1'b0;
                    if (!model_cfg.auto_repeat_on)
                        st_rearmed = 1'b1;
                end
                r.accepted = 1'b1;
            end
        end
        else
        begin
            n_acks++;
            if (st_pending)
            begin
                st_pending = 1'b0;
                // auto-repeat: a held button counts again from zero
                if (model_cfg.auto_repeat_on)
                begin
                    st_rearmed     = 1'b1;
                    st_hold        = '0;
                    st_was_pressed = 1'b1;
                end
                r.accepted = 1'b1;
                n_cleared++;
            end
        end
        r.service_pending = st_pending;
        r.pressed_now     = st_last_pressed;
        return r;
    endfunction

    function automatic void flag_mismatch(string what, rsp_word_t due, rsp_word_t got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("word %0d (%s): exp acc=%b pend=%b prs=%b, got acc=%b pend=%b prs=%b",
                     words_out, what, due.accepted, due.service_pending, due.pressed_now,
                     got.accepted, got.service_pending, got.pressed_now);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: predicts on acceptance, then offers the next word
    // unless the idle draw says to leave a gap.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : req_drive
        req_word_t nxt;
        if (!rst_n)
        begin
            req_if.valid     <= 1'b0;
            req_if.opcode    <= OP_TICK;
            req_if.pin_level <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                rsp_due_q.push_back(button_qualify('{op: op_t'(req_if.opcode),
                                                     pin: req_if.pin_level}));
            if (!req_if.valid || req_if.ready)
            begin
                if (req_word_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct)
                begin
                    nxt = req_word_q.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.opcode    <= nxt.op;
                    req_if.pin_level <= nxt.pin;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: compares each accepted word against the oldest
    // prediction; owns ready, including the long hold-off count.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : rsp_check
        rsp_word_t due;
        rsp_word_t got;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_seen    <= 0;
            hold_left    <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = '{accepted: rsp_if.accepted,
                        service_pending: rsp_if.service_pending,
                        pressed_now: rsp_if.pressed_now};
                words_out++;
                if (rsp_due_q.size() == 0)
                    flag_mismatch("nothing due", '0, got);
                else
                begin
                    due = rsp_due_q.pop_front();
                    if (got.accepted !== due.accepted ||
                        got.service_pending !== due.service_pending ||
                        got.pressed_now !== due.pressed_now)
                        flag_mismatch("field differs", due, got);
                end
            end
            if (hold_asks != hold_seen)
            begin
                hold_seen    <= hold_asks;
                hold_left    <= HOLD_OFF_CYCLES;
                rsp_if.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // Watchdog: any stretch without a handshake on either side is a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Configuration writes and stimulus helpers
    // ------------------------------------------------------------------------
    // APB write: setup phase, then access phase, in which the register takes the value.
    task automatic reg_write(reg_idx_t idx, logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PULLED_UP:      model_cfg.pulled_up      = data[0];
            REG_NORMALLY_OPEN:  model_cfg.normally_open  = data[0];
            REG_DEBOUNCE_TICKS: model_cfg.debounce_ticks =
                (data[15:0] < MIN_DEBOUNCE) ? 16'(MIN_DEBOUNCE) : data[15:0];
            REG_AUTO_REPEAT_ON: model_cfg.auto_repeat_on = data[0];
            default: ;
        endcase
    endtask

    task automatic push_word(op_t op, logic pin);
        req_word_q.push_back('{op: op, pin: pin});
        phase_words++;
    endtask

    // Tick whose pin level decodes to the wanted pressed state.
    task automatic push_tick(logic pressed);
        push_word(OP_TICK, pressed ^ model_cfg.pulled_up ^ model_cfg.normally_open ^ 1'b1);
    endtask

    task automatic push_run(logic pressed, int n);
        repeat (n) push_tick(pressed);
    endtask

    task automatic push_ack();
        push_word(OP_ACK, 1'($urandom_range(0, 1)));
    endtask

    // One button episode: release, a hold near the debounce time with rare
    // bounce, up to two random samples, acks; one in five is plain noise.
    task automatic push_episode();
        int deb;
        deb = int'(model_cfg.debounce_ticks);
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(4, 12))
                push_word(($urandom_range(0, 3) == 0) ? OP_ACK : OP_TICK,
                          1'($urandom_range(0, 1)));
            return;
        end
        push_run(1'b0, $urandom_range(1, 4));
        repeat (deb + $urandom_range(0, 8) - 3)
            push_tick($urandom_range(0, 29) != 0);
        repeat ($urandom_range(0, 2))
            push_word(OP_TICK, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 2))
            push_ack();
        // keep holding through a repeat interval
        if (model_cfg.auto_repeat_on && $urandom_range(0, 1) == 1)
        begin
            push_run(1'b1, deb + $urandom_range(0, 3));
            push_ack();
        end
    endtask

    // Sender pause: nothing queued, nothing offered, nothing still due.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_word_q.size() != 0 || req_if.valid || rsp_due_q.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Random phase under one setting; upper register bits get garbage.
    task automatic run_phase(logic pu, logic norm_open, logic [15:0] deb, logic rep,
                             int in_pct, int out_pct, bit hold_off);
        reg_write(REG_PULLED_UP, {31'($urandom), pu});
        reg_write(REG_NORMALLY_OPEN, {31'($urandom), norm_open});
        reg_write(REG_DEBOUNCE_TICKS, {16'($urandom), deb});
        reg_write(REG_AUTO_REPEAT_ON, {31'($urandom), rep});
        @(negedge clk);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        phase_words   = 0;
        while (phase_words < RANDOM_PER_PHASE)
            push_episode();
        if (hold_off)
            hold_asks++;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.opcode    = OP_TICK;
        req_if.pin_level = 1'b0;
        rsp_if.ready     = 1'b0;

        model_cfg.pulled_up      = 1'b1;
        model_cfg.normally_open  = 1'b1;
        model_cfg.debounce_ticks = 16'(MIN_DEBOUNCE);
        model_cfg.auto_repeat_on = 1'b0;
        st_was_pressed  = 1'b0;
        st_rearmed      = 1'b0;
        st_pending      = 1'b0;
        st_last_pressed = 1'b0;
        st_hold         = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: debounce write under the floor clamps, upper bits ignored.
        // Pull-up + normally open: pin low means pressed.
        reg_write(REG_DEBOUNCE_TICKS, 32'hFFFF_0005);
        reg_write(REG_PULLED_UP, 32'hFFFF_FFFF);
        @(negedge clk);
        push_word(OP_ACK, 1'b0);        // ack with nothing pending, both pins
        push_word(OP_ACK, 1'b1);
        push_word(OP_TICK, 1'b1);       // release rearms
        push_run(1'b1, 21);             // press edge + debounce time -> pending
        push_word(OP_TICK, 1'b1);       // refused while pending, sample kept
        push_word(OP_TICK, 1'b0);
        push_word(OP_ACK, 1'b0);        // clears pending
        push_word(OP_ACK, 1'b1);        // nothing left to clear
        wait_drained();

        // Random phases over polarity, debounce and repeat settings,
        // each with its own idling mix.
        run_phase(1'b1, 1'b1, 16'd20, 1'b0,  0,  0, 1'b1);
        run_phase(1'b0, 1'b1, 16'd21, 1'b1, 71,  0, 1'b0);
        run_phase(1'b1, 1'b0, 16'd19, 1'b1,  0, 71, 1'b0);
        run_phase(1'b0, 1'b0, 16'd35, 1'b0, 22, 22, 1'b0);
        run_phase(1'b1, 1'b1, 16'd20, 1'b1, 22, 22, 1'b0);
        run_phase(1'b0, 1'b1, 16'd27, 1'b0,  0,  0, 1'b0);

        // Repeat off: qualify once, ack, then keep holding; no second raise
        // without a release in between.
        reg_write(REG_DEBOUNCE_TICKS, 32'd20);
        reg_write(REG_AUTO_REPEAT_ON, 32'd0);
        @(negedge clk);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        push_ack();
        push_tick(1'b0);
        push_run(1'b1, 21);
        push_ack();
        push_run(1'b1, 30);
        wait_drained();
        // Max debounce with repeat on: a short hold never qualifies.
        reg_write(REG_DEBOUNCE_TICKS, 32'h0000_FFFF);
        reg_write(REG_AUTO_REPEAT_ON, 32'd1);
        @(negedge clk);
        push_run(1'b1, 3);
        push_ack();
        push_run(1'b1, 4);
        push_tick(1'b0);
        push_ack();
        wait_drained();
        repeat (4) @(posedge clk);

        $display("Covered %0d ticks (%0d refused while pending), %0d acks (%0d cleared),",
                 n_ticks, n_refused, n_acks, n_cleared);
        $display("%0d service raises; both polarities, debounce 20..65535, repeat on/off.",
                 n_raised);
        if (mismatches == 0 && rsp_due_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
